>>> rtl/core/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and calendar helpers for the calendar / seconds
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

    // last year offset that the year search may reach
    localparam logic [7:0] YEAR_LIMIT = 8'd255;

    // conversion direction codes
    localparam logic FUNC_TO_SECONDS = 1'b0;
    localparam logic FUNC_TO_DATE    = 1'b1;

    // divisors used when splitting a seconds count
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    // day count of one year or one month
    typedef logic [8:0] csc_days_t;

    // one result beat
    typedef struct packed {
        logic [31:0] seconds;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } csc_result_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } csc_status_t;

    // leap rule for offsets from 2000: only 2100 and 2200 are skipped centuries
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
    endfunction

    function automatic csc_days_t days_of_year(input logic [7:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    // month index from 0; indices past december count 30 days
    function automatic csc_days_t days_of_month(input logic [7:0] y,
                                                input logic [7:0] idx);
        csc_days_t d;
        if (idx >= 8'd12) begin
            d = 9'd30;
        end
        else begin
            case (idx[3:0])
                4'd1:    d = is_leap(y) ? 9'd29 : 9'd28;
                4'd3:    d = 9'd30;
                4'd5:    d = 9'd30;
                4'd8:    d = 9'd30;
                4'd10:   d = 9'd30;
                default: d = 9'd31;
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/csc_addsub.sv
// ----------------------------------------------------------------------------
// csc_addsub
// Shared 32-bit adder / subtractor. The carry out of a subtract is set when
// a is not below b, which the sequencer uses as its compare.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_addsub (
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic        sub,
    output logic [31:0]      sum,
    output logic             carry
);

    logic [31:0] b_op;
    logic [32:0] full;

    // two's complement subtract through inverted operand and carry in
    assign b_op  = sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_op} + {32'b0, sub};
    assign sum   = full[31:0];
    assign carry = full[32];

endmodule

`default_nettype wire

>>> rtl/core/csc_ctrl.sv
// ----------------------------------------------------------------------------
// csc_ctrl
// Sequencer and working registers. Every arithmetic step (year and month
// accumulation, scaling, compare and subtract against shifted day, hour and
// minute lengths) goes through one shared adder / subtractor, one step per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 func,
    input  wire logic [31:0]          seconds_in,
    input  wire logic [7:0]           year_in,
    input  wire logic [3:0]           month_in,
    input  wire logic [4:0]           day_in,
    input  wire logic [4:0]           hour_in,
    input  wire logic [5:0]           minute_in,
    input  wire logic [5:0]           second_in,
    input  wire logic                 out_free,
    output csc_pkg::csc_status_t      status,
    output csc_pkg::csc_result_t      result
);

    import csc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_D_YEAR   = 4'd1;
    localparam logic [3:0] ST_D_MONTH  = 4'd2;
    localparam logic [3:0] ST_D_DAY    = 4'd3;
    localparam logic [3:0] ST_D_MUL24  = 4'd4;
    localparam logic [3:0] ST_D_HOUR   = 4'd5;
    localparam logic [3:0] ST_D_MUL60M = 4'd6;
    localparam logic [3:0] ST_D_MIN    = 4'd7;
    localparam logic [3:0] ST_D_MUL60S = 4'd8;
    localparam logic [3:0] ST_D_SEC    = 4'd9;
    localparam logic [3:0] ST_S_DIVD   = 4'd10;
    localparam logic [3:0] ST_S_DIVH   = 4'd11;
    localparam logic [3:0] ST_S_DIVM   = 4'd12;
    localparam logic [3:0] ST_S_YEAR   = 4'd13;
    localparam logic [3:0] ST_S_MONTH  = 4'd14;
    localparam logic [3:0] ST_FINISH   = 4'd15;

    // highest shift of each divisor that still fits the quotient width
    localparam logic [7:0] DAY_SHIFT   = 8'd15;
    localparam logic [7:0] HOUR_SHIFT  = 8'd4;
    localparam logic [7:0] MIN_SHIFT   = 8'd5;
    localparam logic [7:0] MONTH_LIMIT = 8'd12;

    logic [3:0]  state_reg, state_next;
    logic        func_reg, func_next;
    logic [7:0]  year_in_reg, year_in_next;
    logic [7:0]  mon_reg, mon_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  mi_reg, mi_next;
    logic [5:0]  se_reg, se_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] days_reg, days_next;
    logic [7:0]  yr_reg, yr_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic [31:0] op_a, op_b;
    logic        op_sub;
    logic [31:0] op_sum;
    logic        op_carry;
    logic [31:0] day_m1;
    logic [31:0] div_acc;
    logic        done;
    logic        to_date;

    // day - 1 as a 32-bit value, all ones for day zero
    assign day_m1 = {{27{day_reg == 5'd0}}, day_reg - 5'd1};

    // operand selection for the shared unit
    always_comb
    begin
        op_a   = acc_reg;
        op_b   = 32'd0;
        op_sub = 1'b0;
        case (state_reg)
            ST_D_YEAR:   op_b = {23'd0, days_of_year(yr_reg)};
            ST_D_MONTH:  op_b = {23'd0, days_of_month(year_in_reg, cnt_reg)};
            ST_D_DAY:    op_b = day_m1;
            ST_D_MUL24:
            begin
                op_a = {acc_reg[27:0], 4'd0};
                op_b = {acc_reg[28:0], 3'd0};
            end
            ST_D_HOUR:   op_b = {27'd0, hr_reg};
            ST_D_MUL60M,
            ST_D_MUL60S:
            begin
                op_a   = {acc_reg[25:0], 6'd0};
                op_b   = {acc_reg[29:0], 2'd0};
                op_sub = 1'b1;
            end
            ST_D_MIN:    op_b = {26'd0, mi_reg};
            ST_D_SEC:    op_b = {26'd0, se_reg};
            ST_S_DIVD:
            begin
                op_b   = SECS_PER_DAY << cnt_reg[3:0];
                op_sub = 1'b1;
            end
            ST_S_DIVH:
            begin
                op_b   = SECS_PER_HOUR << cnt_reg[3:0];
                op_sub = 1'b1;
            end
            ST_S_DIVM:
            begin
                op_b   = SECS_PER_MIN << cnt_reg[3:0];
                op_sub = 1'b1;
            end
            ST_S_YEAR:
            begin
                op_a   = {16'd0, days_reg};
                op_b   = {23'd0, days_of_year(yr_reg)};
                op_sub = 1'b1;
            end
            ST_S_MONTH:
            begin
                op_a   = {16'd0, days_reg};
                op_b   = {23'd0, days_of_month(yr_reg, cnt_reg)};
                op_sub = 1'b1;
            end
            default:
            begin
                op_a   = acc_reg;
                op_b   = 32'd0;
                op_sub = 1'b0;
            end
        endcase
    end

    csc_addsub u_addsub (
        .a     (op_a),
        .b     (op_b),
        .sub   (op_sub),
        .sum   (op_sum),
        .carry (op_carry)
    );

    // one compare and subtract step, remainder kept when the multiple does not fit
    assign div_acc = op_carry ? op_sum : acc_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        year_in_next = year_in_reg;
        mon_next     = mon_reg;
        day_next     = day_reg;
        hr_next      = hr_reg;
        mi_next      = mi_reg;
        se_next      = se_reg;
        acc_next     = acc_reg;
        days_next    = days_reg;
        yr_next      = yr_reg;
        cnt_next     = cnt_reg;
        done         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next    = func;
                    year_in_next = year_in;
                    mon_next     = {4'd0, month_in} + 8'hFF;
                    day_next     = day_in;
                    hr_next      = hour_in;
                    mi_next      = minute_in;
                    se_next      = second_in;
                    yr_next      = 8'd0;
                    if (func == FUNC_TO_DATE)
                    begin
                        acc_next   = seconds_in;
                        cnt_next   = DAY_SHIFT;
                        state_next = ST_S_DIVD;
                    end
                    else
                    begin
                        acc_next   = 32'd0;
                        cnt_next   = 8'd0;
                        state_next = ST_D_YEAR;
                    end
                end
            end
            // whole years before the given one
            ST_D_YEAR:
            begin
                if (yr_reg == year_in_reg)
                begin
                    cnt_next   = 8'd0;
                    state_next = ST_D_MONTH;
                end
                else
                begin
                    acc_next = op_sum;
                    yr_next  = yr_reg + 8'd1;
                end
            end
            // whole months before the given one
            ST_D_MONTH:
            begin
                if (cnt_reg == mon_reg)
                begin
                    state_next = ST_D_DAY;
                end
                else
                begin
                    acc_next = op_sum;
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            ST_D_DAY:
            begin
                acc_next   = op_sum;
                state_next = ST_D_MUL24;
            end
            ST_D_MUL24:
            begin
                acc_next   = op_sum;
                state_next = ST_D_HOUR;
            end
            ST_D_HOUR:
            begin
                acc_next   = op_sum;
                state_next = ST_D_MUL60M;
            end
            ST_D_MUL60M:
            begin
                acc_next   = op_sum;
                state_next = ST_D_MIN;
            end
            ST_D_MIN:
            begin
                acc_next   = op_sum;
                state_next = ST_D_MUL60S;
            end
            ST_D_MUL60S:
            begin
                acc_next   = op_sum;
                state_next = ST_D_SEC;
            end
            ST_D_SEC:
            begin
                acc_next   = op_sum;
                state_next = ST_FINISH;
            end
            // seconds into days and time of day
            ST_S_DIVD:
            begin
                acc_next  = div_acc;
                days_next = {days_reg[14:0], op_carry};
                cnt_next  = cnt_reg - 8'd1;
                if (cnt_reg == 8'd0)
                begin
                    cnt_next   = HOUR_SHIFT;
                    state_next = ST_S_DIVH;
                end
            end
            // time of day into hours and the rest of the hour
            ST_S_DIVH:
            begin
                acc_next = div_acc;
                hr_next  = {hr_reg[3:0], op_carry};
                cnt_next = cnt_reg - 8'd1;
                if (cnt_reg == 8'd0)
                begin
                    cnt_next   = MIN_SHIFT;
                    state_next = ST_S_DIVM;
                end
            end
            // rest of the hour into minutes and seconds
            ST_S_DIVM:
            begin
                acc_next = div_acc;
                mi_next  = {mi_reg[4:0], op_carry};
                cnt_next = cnt_reg - 8'd1;
                if (cnt_reg == 8'd0)
                begin
                    se_next    = div_acc[5:0];
                    yr_next    = 8'd0;
                    cnt_next   = 8'd0;
                    state_next = ST_S_YEAR;
                end
            end
            // peel off whole years
            ST_S_YEAR:
            begin
                if ((yr_reg == YEAR_LIMIT) || !op_carry)
                begin
                    cnt_next   = 8'd0;
                    state_next = ST_S_MONTH;
                end
                else
                begin
                    days_next = op_sum[15:0];
                    yr_next   = yr_reg + 8'd1;
                end
            end
            // peel off whole months
            ST_S_MONTH:
            begin
                if ((cnt_reg == MONTH_LIMIT) || !op_carry)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    days_next = op_sum[15:0];
                    cnt_next  = cnt_reg + 8'd1;
                end
            end
            // hand the result over once the output register is free
            ST_FINISH:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        year_in_reg <= year_in_next;
        mon_reg     <= mon_next;
        day_reg     <= day_next;
        hr_reg      <= hr_next;
        mi_reg      <= mi_next;
        se_reg      <= se_next;
        acc_reg     <= acc_next;
        days_reg    <= days_next;
        yr_reg      <= yr_next;
        cnt_reg     <= cnt_next;
    end

    assign to_date = (func_reg == FUNC_TO_DATE);

    // result assembly, inactive direction reads as zero
    always_comb
    begin
        result.seconds = to_date ? 32'd0 : acc_reg;
        result.year    = to_date ? yr_reg : 8'd0;
        result.month   = to_date ? (cnt_reg[3:0] + 4'd1) : 4'd0;
        result.day     = to_date ? (days_reg[4:0] + 5'd1) : 5'd0;
        result.hour    = to_date ? hr_reg : 5'd0;
        result.minute  = to_date ? mi_reg : 6'd0;
        result.second  = to_date ? se_reg : 6'd0;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done;

endmodule

`default_nettype wire

>>> rtl/core/calendar_seconds_converter_core.sv
// ----------------------------------------------------------------------------
// calendar_seconds_converter_core
// Converts between a calendar date and time (years after 2000) and seconds
// since 2000-01-01 00:00:00 in either direction, one beat at a time.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  func, seconds_in, year_in, month_in,
//                                 day_in, hour_in, minute_in, second_in
//   out      out_valid / out_stall seconds_out, year_out, month_out, day_out,
//                                 hour_out, minute_out, second_out
//
// date to seconds: the year and month loops add whole years and months, then
//   day, hour, minute and second are added with scaling in between
// seconds to date: 16, 5 and 6 compare and subtract steps against shifted
//   day, hour and minute lengths, then the year and month loops
// in_stall is high while a conversion runs and while its result waits for a
//   held output beat; a result in the output register waits there while the
//   next beat is taken
// rst_n clears the sequencer and the output valid asynchronously
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_seconds_converter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] seconds_in,
    input  wire logic [7:0]  year_in,
    input  wire logic [3:0]  month_in,
    input  wire logic [4:0]  day_in,
    input  wire logic [4:0]  hour_in,
    input  wire logic [5:0]  minute_in,
    input  wire logic [5:0]  second_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      seconds_out,
    output logic [7:0]       year_out,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic [4:0]       hour_out,
    output logic [5:0]       minute_out,
    output logic [5:0]       second_out
);

    import csc_pkg::*;

    csc_status_t status;
    csc_result_t result;
    csc_result_t result_reg;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        start;

    assign in_stall = status.busy;
    assign start    = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    csc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .seconds_in (seconds_in),
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .hour_in    (hour_in),
        .minute_in  (minute_in),
        .second_in  (second_in),
        .out_free   (out_free),
        .status     (status),
        .result     (result)
    );

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign seconds_out = result_reg.seconds;
    assign year_out    = result_reg.year;
    assign month_out   = result_reg.month;
    assign day_out     = result_reg.day;
    assign hour_out    = result_reg.hour;
    assign minute_out  = result_reg.minute;
    assign second_out  = result_reg.second;

`ifndef NO_ASSERTIONS
    // a finished result never lands on a beat that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.done && out_valid_reg && out_stall))
        else $error("result written over a stalled output beat");

    // the input side reopens only after a result was handed over
    a_reopen_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> $past(status.done))
        else $error("input reopened without a finished result");

    // time of day from the dividers stays in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hour_out < 5'd24) && (minute_out < 6'd60) && (second_out < 6'd60)))
        else $error("time of day out of range");
`endif

endmodule

`default_nettype wire
